// ----- sv/rgb_to_hsb_convert_unit_assert.svh -----
// assertion macros shared by the rgb to hsb conversion modules
`ifndef RGB_TO_HSB_CONVERT_UNIT_ASSERT_SVH
`define RGB_TO_HSB_CONVERT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rthc check failed");
`define RTHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rthc check failed");
`else
`define RTHC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RTHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rthc_pkg.sv -----
// types and constants for the rgb to hsb conversion unit
package rthc_pkg;

    localparam int ChanW    = 8;
    localparam int FracW    = 16;
    localparam int RemW     = 11;
    localparam int NumCells = FracW;

    localparam logic [FracW-1:0] OFFSET_RED   = 16'd0;
    localparam logic [FracW-1:0] OFFSET_GREEN = 16'd21845;
    localparam logic [FracW-1:0] OFFSET_BLUE  = 16'd43691;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } rthc_sector_t;

    typedef struct packed {
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } rthc_pixel_t;

    typedef struct packed {
        logic [FracW-1:0] hue_out;
        logic [FracW-1:0] saturation_out;
        logic [ChanW-1:0] brightness_out;
    } rthc_hsb_t;

    // one restoring divider lane: partial remainder, dividend bits shifting
    // out on top while quotient bits shift in at the bottom, divisor
    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [FracW-1:0] bits;
        logic [RemW-1:0]  den;
    } rthc_div_t;

    typedef struct packed {
        rthc_div_t        sat;
        rthc_div_t        hue;
        logic             neg;
        rthc_sector_t     sector;
        logic             grey;
        logic [ChanW-1:0] bright;
    } rthc_stage_t;

endpackage

// ----- sv/rthc_front.sv -----
// front stage: max, min, sector and divider setup for one pixel
module rthc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    input  rthc_pkg::rthc_pixel_t pixel,
    output logic                 ready_up,
    output logic                 valid,
    output rthc_pkg::rthc_stage_t stage,
    input  logic                 ready_dn
);
    import rthc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    rthc_stage_t       stage_reg;
    rthc_stage_t       stage_next;
    logic [ChanW-1:0]  mx;
    logic [ChanW-1:0]  mn;
    logic [ChanW-1:0]  delta;
    logic signed [ChanW:0] diff;
    logic [ChanW-1:0]  mag;
    logic [23:0]       sat_num;
    rthc_sector_t      sector;

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        mx = pixel.red_in;
        mn = pixel.red_in;
        if (pixel.green_in > mx)
        begin
            mx = pixel.green_in;
        end
        if (pixel.blue_in > mx)
        begin
            mx = pixel.blue_in;
        end
        if (pixel.green_in < mn)
        begin
            mn = pixel.green_in;
        end
        if (pixel.blue_in < mn)
        begin
            mn = pixel.blue_in;
        end
        delta = mx - mn;

        // first channel in red, green, blue order that holds the max wins
        if (pixel.red_in == mx)
        begin
            sector = SECTOR_RED;
            diff   = $signed({1'b0, pixel.green_in}) - $signed({1'b0, pixel.blue_in});
        end
        else if (pixel.green_in == mx)
        begin
            sector = SECTOR_GREEN;
            diff   = $signed({1'b0, pixel.blue_in}) - $signed({1'b0, pixel.red_in});
        end
        else
        begin
            sector = SECTOR_BLUE;
            diff   = $signed({1'b0, pixel.red_in}) - $signed({1'b0, pixel.green_in});
        end
        mag = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];

        // delta * 65535 without a multiplier
        sat_num = {delta, 16'h0000} - 24'(delta);

        stage_next.sat.rem  = RemW'(sat_num[23:16]);
        stage_next.sat.bits = sat_num[15:0];
        stage_next.sat.den  = RemW'(mx);
        stage_next.hue.rem  = RemW'(mag);
        stage_next.hue.bits = '0;
        stage_next.hue.den  = RemW'({delta, 2'b00}) + RemW'({delta, 1'b0});
        stage_next.neg      = diff[ChanW];
        stage_next.sector   = sector;
        stage_next.grey     = (delta == '0);
        stage_next.bright   = mx;

        valid_next = pixel_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

// ----- sv/rthc_div_cell.sv -----
// one cell of the divider chain: a restoring step on both lanes
module rthc_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  rthc_pkg::rthc_stage_t stage_in,
    output logic                  ready_up,
    output logic                  valid,
    output rthc_pkg::rthc_stage_t stage,
    input  logic                  ready_dn
);
    import rthc_pkg::*;

    `include "rgb_to_hsb_convert_unit_assert.svh"

    logic        valid_reg;
    logic        valid_next;
    rthc_stage_t stage_reg;
    rthc_stage_t stage_next;

    function automatic rthc_div_t div_step(input rthc_div_t lane);
        logic [RemW:0] trial;
        logic          fits;
        rthc_div_t     res;
        trial    = {lane.rem, lane.bits[FracW-1]};
        fits     = (trial >= {1'b0, lane.den});
        res.rem  = fits ? RemW'(trial - {1'b0, lane.den}) : RemW'(trial);
        res.bits = {lane.bits[FracW-2:0], fits};
        res.den  = lane.den;
        return res;
    endfunction

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        stage_next     = stage_in;
        stage_next.sat = div_step(stage_in.sat);
        stage_next.hue = div_step(stage_in.hue);
        valid_next     = valid_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

    `RTHC_ASSERT_NOW(a_sat_rem_bound, clk, rst_n, valid_reg && !stage_reg.grey, stage_reg.sat.rem < stage_reg.sat.den)
    `RTHC_ASSERT_NOW(a_hue_rem_bound, clk, rst_n, valid_reg && !stage_reg.grey, stage_reg.hue.rem < stage_reg.hue.den)
    `RTHC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid_reg && !ready_dn, valid_reg && $stable(stage_reg))

endmodule

// ----- sv/rgb_to_hsb_convert_unit.sv -----
// top level of the rgb to hsb conversion unit
//
// pixel channel: red_in, green_in, blue_in (8 bits each) with pixel_valid and
// pixel_stall; a transfer happens on a clock edge with valid high, stall low.
// hsb channel: hue_out and saturation_out (16 bits), brightness_out (8 bits)
// with hsb_valid and hsb_stall, same transfer rule.
// a transferred pixel is loaded into the setup stage (max, min, sector), then
// passes a chain of 16 divider cells that each settle one quotient bit of
// saturation and hue, then one output register that drives hsb_valid.
// throughput is one pixel per cycle while the receiver does not stall; each
// cell only waits on the cell after it, so bubbles close up and a held result
// does not stop the front from filling empty cells.
// when the receiver stalls, the result register holds and stall passes back
// combinationally through occupied cells; pixel_stall rises only once every
// stage is occupied. reset clears the valid flags, not the data registers.
module rgb_to_hsb_convert_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  rthc_pkg::rthc_pixel_t pixel,
    output logic                  hsb_valid,
    input  logic                  hsb_stall,
    output rthc_pkg::rthc_hsb_t   hsb
);
    import rthc_pkg::*;

    `include "rgb_to_hsb_convert_unit_assert.svh"

    logic [NumCells:0] chain_valid;
    logic [NumCells:0] chain_ready;
    rthc_stage_t       chain_stage [NumCells+1];
    logic              front_ready;
    logic              out_en;
    logic              hsb_valid_reg;
    logic              hsb_valid_next;
    rthc_hsb_t         hsb_reg;
    rthc_hsb_t         hsb_next;
    rthc_stage_t       last;
    logic [FracW-1:0]  offset;
    logic [FracW-1:0]  quot;

    rthc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .ready_up    (front_ready),
        .valid       (chain_valid[0]),
        .stage       (chain_stage[0]),
        .ready_dn    (chain_ready[0])
    );

    assign pixel_stall = !front_ready;

    genvar i;
    generate
        for (i = 0; i < NumCells; i++)
        begin : g_cell
            rthc_div_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .valid_in (chain_valid[i]),
                .stage_in (chain_stage[i]),
                .ready_up (chain_ready[i]),
                .valid    (chain_valid[i+1]),
                .stage    (chain_stage[i+1]),
                .ready_dn (chain_ready[i+1])
            );
        end
    endgenerate

    assign out_en                = !hsb_valid_reg || !hsb_stall;
    assign chain_ready[NumCells] = out_en;
    assign last                  = chain_stage[NumCells];

    always_comb
    begin
        unique case (last.sector)
            SECTOR_RED:   offset = OFFSET_RED;
            SECTOR_GREEN: offset = OFFSET_GREEN;
            SECTOR_BLUE:  offset = OFFSET_BLUE;
            default:      offset = OFFSET_RED;
        endcase
    end

    always_comb
    begin
        // magnitude quotient, sign put back so the quotient truncates toward zero
        quot = last.neg ? FracW'(-last.hue.bits) : last.hue.bits;
        if (last.grey)
        begin
            hsb_next.hue_out        = '0;
            hsb_next.saturation_out = '0;
        end
        else
        begin
            hsb_next.hue_out        = offset + quot;
            hsb_next.saturation_out = last.sat.bits;
        end
        hsb_next.brightness_out = last.bright;
        hsb_valid_next          = chain_valid[NumCells];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsb_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            hsb_valid_reg <= hsb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hsb_reg <= hsb_next;
        end
    end

    assign hsb_valid = hsb_valid_reg;
    assign hsb       = hsb_reg;

    `RTHC_ASSERT_NOW(a_grey_hue_zero, clk, rst_n, hsb_valid_reg && hsb_reg.saturation_out == '0, hsb_reg.hue_out == '0)
    `RTHC_ASSERT_NOW(a_black_unsaturated, clk, rst_n, hsb_valid_reg && hsb_reg.brightness_out == '0, hsb_reg.saturation_out == '0)
    `RTHC_ASSERT_NOW(a_empty_out_no_stall, clk, rst_n, !hsb_valid_reg, !pixel_stall)

endmodule
